FILE: rtl/pas_pkg.sv
// Package of the prime sum accumulator: microcode word types, program addresses and the program ROM.
package pas_pkg;

  // Width of the step counter; the program uses ten steps.
  localparam int unsigned PcBits = 4;

  // Datapath operations that one control word can request.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT_D,
    OP_SQUARE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_INC_D,
    OP_ADD_EMIT
  } op_e;

  // Jump conditions; when the condition holds the step counter takes the target.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_NOT_CANDIDATE,
    COND_IS_TWO,
    COND_SQ_GT_N,
    COND_CNT_MORE,
    COND_REM_ZERO
  } cond_e;

  // Extra conditions that share the encoding space are folded into dedicated steps below.
  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [PcBits-1:0] target;
    logic              add;    // Add the candidate to the running sum.
    logic              finish; // End of item: emit if last, else return to wait.
  } ucode_t;

  // Program addresses.
  localparam logic [PcBits-1:0] PC_WAIT    = 4'd0;
  localparam logic [PcBits-1:0] PC_CHECK   = 4'd1;
  localparam logic [PcBits-1:0] PC_TWO     = 4'd2;
  localparam logic [PcBits-1:0] PC_SQUARE  = 4'd3;
  localparam logic [PcBits-1:0] PC_BOUND   = 4'd4;
  localparam logic [PcBits-1:0] PC_DIVSTEP = 4'd5;
  localparam logic [PcBits-1:0] PC_REMTEST = 4'd6;
  localparam logic [PcBits-1:0] PC_NEXT_D  = 4'd7;
  localparam logic [PcBits-1:0] PC_ADD     = 4'd8;
  localparam logic [PcBits-1:0] PC_FINISH  = 4'd9;

  // Program ROM: one control word per step.
  function automatic ucode_t ucode_rom(input logic [PcBits-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_WAIT, add: 1'b0, finish: 1'b0};
    unique case (pc)
      PC_WAIT:    w = '{OP_LOAD,     COND_NO_BEAT,       PC_WAIT,    1'b0, 1'b0};
      PC_CHECK:   w = '{OP_INIT_D,   COND_NOT_CANDIDATE, PC_FINISH,  1'b0, 1'b0};
      PC_TWO:     w = '{OP_NOP,      COND_IS_TWO,        PC_ADD,     1'b0, 1'b0};
      PC_SQUARE:  w = '{OP_SQUARE,   COND_NEVER,         PC_WAIT,    1'b0, 1'b0};
      PC_BOUND:   w = '{OP_DIV_INIT, COND_SQ_GT_N,       PC_ADD,     1'b0, 1'b0};
      PC_DIVSTEP: w = '{OP_DIV_STEP, COND_CNT_MORE,      PC_DIVSTEP, 1'b0, 1'b0};
      PC_REMTEST: w = '{OP_INC_D,    COND_REM_ZERO,      PC_FINISH,  1'b0, 1'b0};
      PC_NEXT_D:  w = '{OP_NOP,      COND_ALWAYS,        PC_SQUARE,  1'b0, 1'b0};
      PC_ADD:     w = '{OP_NOP,      COND_NEVER,         PC_WAIT,    1'b1, 1'b0};
      PC_FINISH:  w = '{OP_ADD_EMIT, COND_NEVER,         PC_WAIT,    1'b0, 1'b1};
      default:    w = '{OP_NOP,      COND_ALWAYS,        PC_WAIT,    1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/prime_sum_accumulator.sv
// Top level of the prime sum accumulator: microcoded trial-division sequencer and datapath.
//
// Usage: signed values arrive as beats on the slave stream (tdata holds value, tlast marks
// the final value of a set). Each value is tested for primality by trial division with
// divisors d = 2, 3, ... while d*d <= n; prime values are added to a 32-bit wrapping sum.
// On the beat with tlast set, one result beat leaves on the master stream carrying the sum
// and a sticky overflow flag, after which both are cleared.
// Sequencing: a value that is negative or below two goes from the check step to finish,
// and two goes through the add step. Otherwise each full trial divisor runs the square,
// bound check, VALUE_BITS-1 bit-serial remainder steps, remainder test and jump. A prime
// ends at the bound check that finds d*d > n; a composite ends at the remainder test of
// its smallest factor. For 16-bit values the slowest value is the square of 181, and only
// one value is in flight at a time.
// On a last value the result is loaded into an output register at the end of the finish
// step, so m_axis_tvalid_o rises as the sequencer returns to wait; the next value is
// accepted while that result waits. If the receiver stalls with a result pending, the next
// last-value result waits in the sequencer until the register frees up.
// Reset clears the sum, the flag, the step counter and the output valid.
module prime_sum_accumulator
  import pas_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: value[VALUE_BITS-1:0], zero padding.
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Fields from bit 0: prime_sum[31:0], overflow, zero padding.
  output logic [39:0]                         m_axis_tdata_o
);

  // Magnitude bits of a candidate, divisor width, square width and bit counter width.
  localparam int unsigned NB = VALUE_BITS - 1;
  localparam int unsigned DB = (NB + 1) / 2 + 1;
  localparam int unsigned SB = 2 * DB;
  localparam int unsigned CB = $clog2(NB + 1);

  logic [PcBits-1:0] pc_q, pc_d;
  ucode_t            uw;
  logic              cond_hit;

  logic [NB-1:0]     n_q, n_d;
  logic              neg_q, neg_d;
  logic              last_q, last_d;
  logic [DB-1:0]     d_q, d_d;
  logic [SB-1:0]     sq_q, sq_d;
  logic [DB-1:0]     rem_q, rem_d;
  logic [NB-1:0]     nsh_q, nsh_d;
  logic [CB-1:0]     cnt_q, cnt_d;
  logic [31:0]       sum_q, sum_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_sum_q, out_sum_d;
  logic              out_ovf_q, out_ovf_d;

  logic              in_beat;
  logic              out_busy;
  logic [DB:0]       rem_shift;
  logic [DB:0]       rem_sub;
  logic [31:0]       sum_next;

  assign uw       = ucode_rom(pc_q);
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_busy = out_valid_q && !m_axis_tready_i;

  assign s_axis_tready_o = (uw.op == OP_LOAD);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_ovf_q, out_sum_q};

  // One remainder step: shift in the next dividend bit, subtract when it fits.
  assign rem_shift = {rem_q, nsh_q[NB-1]};
  assign rem_sub   = rem_shift - {1'b0, d_q};
  assign sum_next  = sum_q + 32'(n_q);

  // Jump condition selection.
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:         cond_hit = 1'b0;
      COND_ALWAYS:        cond_hit = 1'b1;
      COND_NO_BEAT:       cond_hit = !in_beat;
      COND_NOT_CANDIDATE: cond_hit = neg_q || (n_q < NB'(2));
      COND_IS_TWO:        cond_hit = (n_q == NB'(2));
      COND_SQ_GT_N:       cond_hit = (sq_q > SB'(n_q));
      COND_CNT_MORE:      cond_hit = (cnt_q != CB'(1));
      COND_REM_ZERO:      cond_hit = (rem_q == '0);
      default:            cond_hit = 1'b0;
    endcase
  end

  // Step counter: the finish step waits on a busy output or returns to wait.
  always_comb begin
    if (uw.finish) begin
      if (last_q && out_busy) begin
        pc_d = pc_q;
      end else begin
        pc_d = PC_WAIT;
      end
    end else if (cond_hit) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PcBits'(1);
    end
  end

  // Datapath controlled by the current control word.
  always_comb begin
    n_d         = n_q;
    neg_d       = neg_q;
    last_d      = last_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    nsh_d       = nsh_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    out_sum_d   = out_sum_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (uw.op)
      OP_LOAD: begin
        if (in_beat) begin
          n_d    = s_axis_tdata_i[NB-1:0];
          neg_d  = s_axis_tdata_i[VALUE_BITS-1];
          last_d = s_axis_tlast_i;
        end
      end
      OP_INIT_D:   d_d = DB'(2);
      OP_SQUARE:   sq_d = d_q * d_q;
      OP_DIV_INIT: begin
        rem_d = '0;
        nsh_d = n_q;
        cnt_d = CB'(NB);
      end
      OP_DIV_STEP: begin
        if (!rem_sub[DB]) begin
          rem_d = rem_sub[DB-1:0];
        end else begin
          rem_d = rem_shift[DB-1:0];
        end
        nsh_d = {nsh_q[NB-2:0], 1'b0};
        cnt_d = cnt_q - CB'(1);
      end
      OP_INC_D:    d_d = d_q + DB'(1);
      OP_ADD_EMIT: begin
        if (last_q && !out_busy) begin
          out_sum_d   = sum_q;
          out_ovf_d   = ovf_q;
          out_valid_d = 1'b1;
          sum_d       = '0;
          ovf_d       = 1'b0;
        end
      end
      default: ;
    endcase
    // Accumulate a prime candidate; the flag sticks once the sign bit flips up.
    if (uw.add) begin
      sum_d = sum_next;
      if (!sum_q[31] && sum_next[31]) begin
        ovf_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_WAIT;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    neg_q     <= neg_d;
    last_q    <= last_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    rem_q     <= rem_d;
    nsh_q     <= nsh_d;
    cnt_q     <= cnt_d;
    out_sum_q <= out_sum_d;
    out_ovf_q <= out_ovf_d;
  end

endmodule

FILE: bench/prime_sum_accumulator_test.sv
// Self-checking bench for the prime sum accumulator: streams value beats and checks every sum beat.
module prime_sum_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ValueBits = 16;
  localparam int CycleLimit = 4000000;
  // Worst single value (the square of 181) plus the result path, with margin.
  localparam int SettleCycles = 4000;

  // One expected sum beat.
  typedef struct {
    logic [31:0] prime_sum;
    logic        overflow;
  } sum_beat_t;

  // Scoreboard: tracks the running sum of primes and holds the sums still owed by the block.
  class prime_sum_board;
    logic [31:0] sum_acc;
    logic        wrap_seen;
    sum_beat_t   owed_sums[$];
    int          errors;
    int          sets_closed;

    function new();
      sum_acc     = '0;
      wrap_seen   = 1'b0;
      errors      = 0;
      sets_closed = 0;
    endfunction

    // Trial division over d = 2, 3, ... while d*d <= n.
    function bit is_prime_value(logic [ValueBits-1:0] v);
      int n;
      int d;
      if (v[ValueBits-1]) return 1'b0;
      n = int'(v);
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Account for an accepted value beat.
    function void note_value(logic [ValueBits-1:0] v, logic last);
      logic [31:0] next_sum;
      sum_beat_t   owed;
      if (is_prime_value(v)) begin
        next_sum = sum_acc + {{(32-ValueBits){1'b0}}, v};
        if (!sum_acc[31] && next_sum[31]) wrap_seen = 1'b1;
        sum_acc = next_sum;
      end
      if (last) begin
        owed.prime_sum = sum_acc;
        owed.overflow  = wrap_seen;
        owed_sums.push_back(owed);
        sets_closed++;
        sum_acc   = '0;
        wrap_seen = 1'b0;
      end
    endfunction

    // Compare an accepted sum beat with the oldest owed sum.
    function void check_sum(logic [39:0] data);
      sum_beat_t owed;
      if (owed_sums.size() == 0) begin
        $display("%0t: unexpected sum beat, sum %0d overflow %0b",
                 $time, $signed(data[31:0]), data[32]);
        errors++;
        return;
      end
      owed = owed_sums.pop_front();
      if (data[31:0] !== owed.prime_sum) begin
        $display("%0t: prime_sum expected %0d, actual %0d",
                 $time, $signed(owed.prime_sum), $signed(data[31:0]));
        errors++;
      end
      if (data[32] !== owed.overflow) begin
        $display("%0t: overflow expected %0b, actual %0b", $time, owed.overflow, data[32]);
        errors++;
      end
    endfunction

    function int pending();
      return owed_sums.size();
    endfunction

    // Sums still owed when the run ends are failures.
    function void close_out();
      if (owed_sums.size() != 0) begin
        $display("%0t: %0d sum beats never arrived", $time, owed_sums.size());
        errors += owed_sums.size();
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [ValueBits-1:0] s_axis_tdata_i;
  logic                 s_axis_tlast_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [39:0]          m_axis_tdata_o;

  prime_sum_board board;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             cycles;

  prime_sum_accumulator #(
    .VALUE_BITS(ValueBits)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 20 ns clock.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver readiness changes on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sum beats are checked on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_sum(m_axis_tdata_o);
    end
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("prime_sum_accumulator_test: errors");
      $finish;
    end
  end

  // Send one value beat after a random gap and wait until it is taken.
  task automatic send_value(input logic [ValueBits-1:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_value(v, last);
  endtask

  // Hold the sender off until every owed sum has come back.
  task automatic drain_sums();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Random value, mostly small so the trial division stays short.
  function automatic logic [ValueBits-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return ValueBits'($urandom_range(1023));
    if (r < 75) return ValueBits'(-$urandom_range(1024));
    if (r < 90) return ValueBits'($urandom_range(65535));
    return ValueBits'($urandom_range(32767, 30000));
  endfunction

  initial begin
    int count;
    board           = new();
    cycles          = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    send_idle_pct   = 14;
    recv_idle_pct   = 86;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: non-primes below two, two itself, squares of primes, field extremes.
    send_value(16'h8000, 1'b0);
    send_value(16'hFFFF, 1'b0);
    send_value(16'd0, 1'b0);
    send_value(16'd1, 1'b0);
    send_value(16'd2, 1'b1);
    send_value(16'd3, 1'b0);
    send_value(16'd4, 1'b0);
    send_value(16'd9, 1'b0);
    send_value(16'd25, 1'b0);
    send_value(16'd49, 1'b0);
    send_value(16'd121, 1'b0);
    send_value(16'd169, 1'b1);
    send_value(16'd32767, 1'b0);
    send_value(16'd32749, 1'b0);
    send_value(16'd32761, 1'b0);
    send_value(16'd5, 1'b1);
    send_value(16'd7, 1'b1);
    send_value(16'hFFFB, 1'b1);
    send_value(16'h7FF1, 1'b0);
    send_value(16'h0011, 1'b1);

    // Random sets in three idling phases, with a full drain between phases.
    count = 0;
    while (count < 200 || board.sets_closed < 40) begin
      if (count == 70) begin
        drain_sums();
        send_idle_pct = 86;
        recv_idle_pct = 14;
      end else if (count == 140) begin
        drain_sums();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_value(pick_value(), ($urandom_range(4) == 0));
      count++;
    end
    // Close the open set so every value ends up in a checked sum.
    send_value(pick_value(), 1'b1);

    drain_sums();
    repeat (SettleCycles) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("prime_sum_accumulator_test: clean");
    end else begin
      $display("prime_sum_accumulator_test: errors");
    end
    $finish;
  end

endmodule

FILE: prime_sum_accumulator.f
rtl/pas_pkg.sv
rtl/prime_sum_accumulator.sv
bench/prime_sum_accumulator_test.sv
